// ===== src/fpr_pkg.sv =====
`timescale 1ns / 1ps

package fpr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 4;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hFF;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [POS_W-1:0]  pos_t;

    localparam pos_t POS_HUNT1  = 4'd0;
    localparam pos_t POS_HUNT2  = 4'd1;
    localparam pos_t POS_CMD0   = 4'd2;
    localparam pos_t POS_CMD1   = 4'd3;
    localparam pos_t POS_CMD2   = 4'd4;
    localparam pos_t POS_ANGLE  = 4'd5;
    localparam pos_t POS_X0     = 4'd6;
    localparam pos_t POS_X1     = 4'd7;
    localparam pos_t POS_Y0     = 4'd8;
    localparam pos_t POS_Y1     = 4'd9;
    localparam pos_t POS_CHECK  = 4'd10;

endpackage

// ===== src/framed_packet_receiver.sv =====
`timescale 1ns / 1ps

// a result is valid in the cycle after its checksum word is accepted
// throughput: one word per cycle; s_ready drops only while a result waits
//   in the output register and m_ready is low
// the checksum is accumulated one word at a time in a running 8-bit sum
// reset: synchronous active-low aresetn returns the parser to header hunt
//   and empties the output register
module framed_packet_receiver (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_cmd_first,
    output logic [7:0] m_cmd_second,
    output logic [7:0] m_cmd_third,
    output logic [7:0] m_angle_byte,
    output logic [7:0] m_x_first,
    output logic [7:0] m_x_second,
    output logic [7:0] m_y_first,
    output logic [7:0] m_y_second
);

    fpr_pkg::pos_t  pos_reg, pos_next;
    fpr_pkg::byte_t sum_reg, sum_next;
    fpr_pkg::byte_t cmd0_reg, cmd1_reg, cmd2_reg, angle_reg;
    fpr_pkg::byte_t x0_reg, x1_reg, y0_reg, y1_reg;
    logic           m_valid_reg, m_valid_next;
    fpr_pkg::byte_t o_cmd0_reg, o_cmd1_reg, o_cmd2_reg, o_angle_reg;
    fpr_pkg::byte_t o_x0_reg, o_x1_reg, o_y0_reg, o_y1_reg;
    logic           accept;
    logic           load_out;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        load_out = 1'b0;
        if (accept) begin
            case (pos_reg)
                fpr_pkg::POS_HUNT1, fpr_pkg::POS_HUNT2: begin
                    sum_next = '0;
                    pos_next = (s_rx_byte == fpr_pkg::HEADER_BYTE) ?
                               pos_reg + 4'd1 : fpr_pkg::POS_HUNT1;
                end
                fpr_pkg::POS_CMD0, fpr_pkg::POS_CMD1, fpr_pkg::POS_CMD2: begin
                    sum_next = sum_reg + s_rx_byte;
                    pos_next = pos_reg + 4'd1;
                end
                fpr_pkg::POS_ANGLE, fpr_pkg::POS_X0, fpr_pkg::POS_X1,
                fpr_pkg::POS_Y0, fpr_pkg::POS_Y1: begin
                    sum_next = sum_reg - s_rx_byte;
                    pos_next = pos_reg + 4'd1;
                end
                fpr_pkg::POS_CHECK: begin
                    load_out = (s_rx_byte == sum_reg);
                    pos_next = fpr_pkg::POS_HUNT1;
                end
                default: begin
                    // unused codes behave as the first header hunt
                    sum_next = '0;
                    pos_next = (s_rx_byte == fpr_pkg::HEADER_BYTE) ?
                               fpr_pkg::POS_HUNT2 : fpr_pkg::POS_HUNT1;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= fpr_pkg::POS_HUNT1;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // field capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            case (pos_reg)
                fpr_pkg::POS_CMD0:  cmd0_reg  <= s_rx_byte;
                fpr_pkg::POS_CMD1:  cmd1_reg  <= s_rx_byte;
                fpr_pkg::POS_CMD2:  cmd2_reg  <= s_rx_byte;
                fpr_pkg::POS_ANGLE: angle_reg <= s_rx_byte;
                fpr_pkg::POS_X0:    x0_reg    <= s_rx_byte;
                fpr_pkg::POS_X1:    x1_reg    <= s_rx_byte;
                fpr_pkg::POS_Y0:    y0_reg    <= s_rx_byte;
                fpr_pkg::POS_Y1:    y1_reg    <= s_rx_byte;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            o_cmd0_reg  <= cmd0_reg;
            o_cmd1_reg  <= cmd1_reg;
            o_cmd2_reg  <= cmd2_reg;
            o_angle_reg <= angle_reg;
            o_x0_reg    <= x0_reg;
            o_x1_reg    <= x1_reg;
            o_y0_reg    <= y0_reg;
            o_y1_reg    <= y1_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cmd_first  = o_cmd0_reg;
    assign m_cmd_second = o_cmd1_reg;
    assign m_cmd_third  = o_cmd2_reg;
    assign m_angle_byte = o_angle_reg;
    assign m_x_first    = o_x0_reg;
    assign m_x_second   = o_x1_reg;
    assign m_y_first    = o_y0_reg;
    assign m_y_second   = o_y1_reg;

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= fpr_pkg::POS_CHECK)
        else $error("byte position out of range");

    a_check_rehunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && pos_reg == fpr_pkg::POS_CHECK) |=> pos_reg == fpr_pkg::POS_HUNT1)
        else $error("parser did not return to header hunt after checksum");

    a_bad_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && pos_reg == fpr_pkg::POS_HUNT2 && s_rx_byte != fpr_pkg::HEADER_BYTE)
        |=> pos_reg == fpr_pkg::POS_HUNT1)
        else $error("broken header did not restart hunt");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ready && !(accept && pos_reg == fpr_pkg::POS_CHECK))
        |=> !m_valid_reg)
        else $error("result appeared without a checksum word");

    a_sum_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg == fpr_pkg::POS_CMD0) |-> sum_reg == '0)
        else $error("running checksum not cleared at packet start");

endmodule

// ===== tb/framed_packet_receiver_tb.sv =====
`timescale 1ns / 1ps

module framed_packet_receiver_tb;

    localparam int unsigned WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        fpr_pkg::byte_t cmd_first;
        fpr_pkg::byte_t cmd_second;
        fpr_pkg::byte_t cmd_third;
        fpr_pkg::byte_t angle_byte;
        fpr_pkg::byte_t x_first;
        fpr_pkg::byte_t x_second;
        fpr_pkg::byte_t y_first;
        fpr_pkg::byte_t y_second;
    } packet_t;

    logic           aclk      = 1'b0;
    logic           aresetn   = 1'b0;
    logic           s_valid   = 1'b0;
    logic           m_ready   = 1'b0;
    fpr_pkg::byte_t s_rx_byte = '0;
    logic           s_ready;
    logic           m_valid;
    fpr_pkg::byte_t m_cmd_first, m_cmd_second, m_cmd_third, m_angle_byte;
    fpr_pkg::byte_t m_x_first, m_x_second, m_y_first, m_y_second;

    // parser mirror
    fpr_pkg::pos_t parse_pos = fpr_pkg::POS_HUNT1;
    packet_t       parse_pkt = '0;
    packet_t       pending_packets[$];

    bit          gaps_on   = 1'b1;
    bit          stalls_on = 1'b1;
    int unsigned words_sent;
    int unsigned packets_checked;
    int unsigned packets_dropped;
    int unsigned errors;
    int unsigned quiet_cycles;

    framed_packet_receiver dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cmd_first  (m_cmd_first),
        .m_cmd_second (m_cmd_second),
        .m_cmd_third  (m_cmd_third),
        .m_angle_byte (m_angle_byte),
        .m_x_first    (m_x_first),
        .m_x_second   (m_x_second),
        .m_y_first    (m_y_first),
        .m_y_second   (m_y_second)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic fpr_pkg::byte_t checksum_of(packet_t p);
        return p.cmd_first + p.cmd_second + p.cmd_third - p.angle_byte
               - p.x_first - p.x_second - p.y_first - p.y_second;
    endfunction

    function automatic void parse_word(fpr_pkg::byte_t b);
        case (parse_pos)
            fpr_pkg::POS_CMD0:  parse_pkt.cmd_first  = b;
            fpr_pkg::POS_CMD1:  parse_pkt.cmd_second = b;
            fpr_pkg::POS_CMD2:  parse_pkt.cmd_third  = b;
            fpr_pkg::POS_ANGLE: parse_pkt.angle_byte = b;
            fpr_pkg::POS_X0:    parse_pkt.x_first    = b;
            fpr_pkg::POS_X1:    parse_pkt.x_second   = b;
            fpr_pkg::POS_Y0:    parse_pkt.y_first    = b;
            fpr_pkg::POS_Y1:    parse_pkt.y_second   = b;
            fpr_pkg::POS_CHECK: begin
                if (b == checksum_of(parse_pkt))
                    pending_packets.push_back(parse_pkt);
                else
                    packets_dropped++;
            end
            default: ;
        endcase
        if (parse_pos == fpr_pkg::POS_CHECK) begin
            parse_pos = fpr_pkg::POS_HUNT1;
        end else if (parse_pos >= fpr_pkg::POS_CMD0 && parse_pos < fpr_pkg::POS_CHECK) begin
            parse_pos = parse_pos + 4'd1;
        end else if (b != fpr_pkg::HEADER_BYTE) begin
            parse_pos = fpr_pkg::POS_HUNT1;
        end else begin
            parse_pos = (parse_pos == fpr_pkg::POS_HUNT2) ? fpr_pkg::POS_CMD0
                                                          : fpr_pkg::POS_HUNT2;
        end
    endfunction

    function automatic void report(string what, fpr_pkg::byte_t want, fpr_pkg::byte_t got);
        if (errors < 10)
            $display("[%0t] packet %0d %s: expected %02h got %02h",
                     $realtime, packets_checked, what, want, got);
        errors++;
    endfunction

    function automatic void check_packet();
        packet_t want;
        packet_t got;
        got = {m_cmd_first, m_cmd_second, m_cmd_third, m_angle_byte,
               m_x_first, m_x_second, m_y_first, m_y_second};
        if (pending_packets.size() == 0) begin
            if (errors < 10)
                $display("[%0t] unexpected packet %016h", $realtime, got);
            errors++;
        end else begin
            want = pending_packets.pop_front();
            if (want.cmd_first != got.cmd_first)
                report("cmd_first", want.cmd_first, got.cmd_first);
            if (want.cmd_second != got.cmd_second)
                report("cmd_second", want.cmd_second, got.cmd_second);
            if (want.cmd_third != got.cmd_third)
                report("cmd_third", want.cmd_third, got.cmd_third);
            if (want.angle_byte != got.angle_byte)
                report("angle_byte", want.angle_byte, got.angle_byte);
            if (want.x_first != got.x_first)
                report("x_first", want.x_first, got.x_first);
            if (want.x_second != got.x_second)
                report("x_second", want.x_second, got.x_second);
            if (want.y_first != got.y_first)
                report("y_first", want.y_first, got.y_first);
            if (want.y_second != got.y_second)
                report("y_second", want.y_second, got.y_second);
        end
        packets_checked++;
    endfunction

    // handshakes sampled mid-cycle, each one completes at the next rising edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                parse_word(s_rx_byte);
            if (m_valid && m_ready)
                check_packet();
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // result side back-pressure
    initial begin
        forever begin
            if (stalls_on && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(20, 60)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    task automatic send_word(input fpr_pkg::byte_t b);
        bit taken;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        words_sent++;
    endtask

    function automatic fpr_pkg::byte_t pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return fpr_pkg::byte_t'($urandom);
        endcase
    endfunction

    task automatic send_packet(input bit corrupt);
        packet_t        p;
        fpr_pkg::byte_t sum;
        p = {pick_byte(), pick_byte(), pick_byte(), pick_byte(),
             pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        sum = checksum_of(p);
        if (corrupt)
            sum = sum ^ fpr_pkg::byte_t'($urandom_range(1, 255));
        send_word(fpr_pkg::HEADER_BYTE);
        send_word(fpr_pkg::HEADER_BYTE);
        for (int i = 7; i >= 0; i--)
            send_word(p[i*8 +: 8]);
        send_word(sum);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (pending_packets.size() != 0)
            @(posedge aclk);
        @(posedge aclk);
    endtask

    // broken headers, extra header byte taken as command, checksum mismatch
    task automatic test_directed();
        fpr_pkg::byte_t seq[$];
        seq = '{8'h00, 8'hFF, 8'h12,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h00, 8'hFD,
                8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h01};
        foreach (seq[i])
            send_word(seq[i]);
    endtask

    task automatic test_packet_traffic(input int unsigned budget);
        int unsigned stop_at;
        stop_at = words_sent + budget;
        while (words_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 3))
                       send_word(fpr_pkg::byte_t'($urandom_range(0, 254)));
                1: begin
                    send_word(fpr_pkg::HEADER_BYTE);
                    send_word(fpr_pkg::byte_t'($urandom_range(0, 254)));
                end
                2: send_packet(1'b1);
                default: send_packet(1'b0);
            endcase
        end
    endtask

    task automatic test_held_sender();
        send_packet(1'b0);
        hold_until_drained();
        send_packet(1'b0);
    endtask

    task automatic test_back_to_back(input int unsigned budget);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        test_packet_traffic(budget);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_packet_traffic(900);
        test_held_sender();
        test_packet_traffic(200);
        test_back_to_back(480);

        s_valid <= 1'b0;
        while (pending_packets.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);

        errors += pending_packets.size();
        $display("%0d words sent, %0d packets delivered and checked, %0d rejected",
                 words_sent, packets_checked, packets_dropped);
        $display("idle gaps and output stalls on both sides, then back-to-back traffic");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
